>>> src/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types, codes and constants for the line sensor steering unit.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int SENSOR_COUNT    = 5;
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int IDX_W           = $clog2(SENSOR_COUNT);
  localparam int OP_W            = 2;
  localparam int DRIVE_W         = 7;
  localparam int POS_W           = 9;
  localparam int MAG_W           = 8;
  localparam int LAP_W           = 5;
  localparam int LOCK_W          = 12;
  localparam int BAND_W          = 8;
  localparam int THR_W           = 10;
  localparam int SCALE_W         = 7;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 12;

  localparam int DIV_NUM_W_DEF = SAMPLE_BITS_DEF + 2 + SCALE_W;
  localparam int DIV_DEN_W_DEF = SAMPLE_BITS_DEF + 3;

  localparam logic [DRIVE_W-1:0] FULL_DUTY    = 7'd100;
  localparam logic [DRIVE_W-1:0] GENTLE_DRIVE = 7'd10;
  localparam logic [DRIVE_W-1:0] STRONG_DRIVE = 7'd5;
  localparam logic [DRIVE_W-1:0] SEARCH_DRIVE = 7'd2;
  localparam logic [LAP_W-1:0]   LAP_CAP      = 5'd31;

  localparam logic [THR_W-1:0]   DARK_THRESHOLD_RST = 10'd500;
  localparam logic [BAND_W-1:0]  NEAR_BAND_RST      = 8'd10;
  localparam logic [BAND_W-1:0]  FAR_BAND_RST       = 8'd20;
  localparam logic [DRIVE_W-1:0] CRUISE_DRIVE_RST   = 7'd60;
  localparam logic [SCALE_W-1:0] POSITION_SCALE_RST = 7'd75;
  localparam logic [LOCK_W-1:0]  LAP_LOCKOUT_RST    = 12'd3000;
  localparam logic [LAP_W-1:0]   LAP_LIMIT_RST      = 5'd16;

  localparam logic signed [2:0] SENSOR_WEIGHT [SENSOR_COUNT] =
    '{-3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd2};

  typedef enum logic [OP_W-1:0] {
    OP_SCAN    = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DARK_THRESHOLD = 3'd0,
    CFG_NEAR_BAND      = 3'd1,
    CFG_FAR_BAND       = 3'd2,
    CFG_CRUISE_DRIVE   = 3'd3,
    CFG_POSITION_SCALE = 3'd4,
    CFG_LAP_LOCKOUT    = 3'd5,
    CFG_LAP_LIMIT      = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPAN,
    S_GWAIT,
    S_ACC,
    S_TOT,
    S_PWAIT,
    S_DRIVE
  } seq_state_t;

  typedef struct packed {
    logic [THR_W-1:0]   dark_threshold;
    logic [BAND_W-1:0]  near_band;
    logic [BAND_W-1:0]  far_band;
    logic [DRIVE_W-1:0] cruise_drive;
    logic [SCALE_W-1:0] position_scale;
    logic [LOCK_W-1:0]  lap_lockout;
    logic [LAP_W-1:0]   lap_limit;
  } cfg_t;

  typedef struct packed {
    logic             tick;
    logic             restart;
    logic             decide;
    logic             all_dark;
    logic             all_mark;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } steer_cmd_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] right_drive;
    logic [DRIVE_W-1:0] left_drive;
    logic [LAP_W-1:0]   lap_count;
    logic               finished;
  } steer_rsp_t;

endpackage

>>> src/lss_in_if.sv
// ----------------------------------------------------------------------------
// lss_in_if
// Input item channel: operation code and five raw sensor readings.
// ----------------------------------------------------------------------------
interface lss_in_if import lss_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [OP_W-1:0]        op;
  logic [SAMPLE_BITS-1:0] sensor_a;
  logic [SAMPLE_BITS-1:0] sensor_b;
  logic [SAMPLE_BITS-1:0] sensor_c;
  logic [SAMPLE_BITS-1:0] sensor_d;
  logic [SAMPLE_BITS-1:0] sensor_e;

  modport source (
    output valid, op, sensor_a, sensor_b, sensor_c, sensor_d, sensor_e,
    input  ready
  );
  modport sink (
    input  valid, op, sensor_a, sensor_b, sensor_c, sensor_d, sensor_e,
    output ready
  );
endinterface

>>> src/lss_out_if.sv
// ----------------------------------------------------------------------------
// lss_out_if
// Result item channel: drives, position, lap status and degenerate flag.
// ----------------------------------------------------------------------------
interface lss_out_if import lss_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [DRIVE_W-1:0]      right_drive;
  logic [DRIVE_W-1:0]      left_drive;
  logic signed [POS_W-1:0] position;
  logic [LAP_W-1:0]        lap_count;
  logic                    finished;
  logic                    degenerate;

  modport source (
    output valid, right_drive, left_drive, position, lap_count, finished, degenerate,
    input  ready
  );
  modport sink (
    input  valid, right_drive, left_drive, position, lap_count, finished, degenerate,
    output ready
  );
endinterface

>>> src/line_sensor_steering_unit.sv
// ----------------------------------------------------------------------------
// line_sensor_steering_unit
// Line follower steering: calibrated centroid, drive bands and lap counting.
// ----------------------------------------------------------------------------
// in_chan takes one item per handshake: op scan, tick or restart with five
// raw sensor readings. A scan yields one result item on out_chan; tick and
// restart are absorbed in the cycle they are accepted and yield none.
// cfg_we/cfg_index/cfg_data write the seven setup registers, one per cycle;
// the user must write them only while no scan is in flight (not enforced).
// A scan is worked through a small sequencer around one shared divider:
// five gain divisions of SAMPLE_BITS steps and one position division of
// SAMPLE_BITS+9 steps; a division is skipped when its span or the total is
// zero. in_chan.ready is low from a scan's acceptance until its result is
// loaded, so a new scan is taken only after the previous result is loaded;
// ticks and restarts leave it high.
// The result waits in an output register; a stalled receiver holds the
// sequencer only when a second result is ready to be loaded.
// Reset returns setup registers to their defaults and clears calibration,
// drive history, lap count, lockout and finish state.
// ----------------------------------------------------------------------------
module line_sensor_steering_unit import lss_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lss_in_if.sink                in_chan,
  lss_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ACC_W  = SAMPLE_BITS + 3;
  localparam int WMAG_W = SAMPLE_BITS + 2;
  localparam int NUM_W  = WMAG_W + SCALE_W;
  localparam int DEN_W  = SAMPLE_BITS + 3;
  localparam int STEP_W = $clog2(NUM_W + 1);
  localparam int CMP_W  = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam logic [SAMPLE_BITS-1:0] SMAX = '1;

  seq_state_t state_r, state_nxt;
  cfg_t       cfg_r;

  logic [SAMPLE_BITS-1:0] raw_in [SENSOR_COUNT];
  logic [SAMPLE_BITS-1:0] raw_r  [SENSOR_COUNT];
  logic [SAMPLE_BITS-1:0] min_r  [SENSOR_COUNT];
  logic [SAMPLE_BITS-1:0] max_r  [SENSOR_COUNT];

  logic                    all_dark_in, all_mark_in;
  logic                    all_dark_r, all_mark_r, degen_r, neg_r;
  logic [IDX_W-1:0]        idx_r;
  logic [SAMPLE_BITS-1:0]  norm_r;
  logic signed [ACC_W-1:0] wsum_r;
  logic [ACC_W-1:0]        total_r;
  logic [MAG_W-1:0]        mag_r;

  logic                      accept, scan_in;
  logic [SAMPLE_BITS-1:0]    span, diff;
  logic [2*SAMPLE_BITS-1:0]  norm_prod;
  logic signed [ACC_W-1:0]   wt_ext, norm_ext, term, wabs;
  logic [WMAG_W-1:0]         wmag;
  logic [POS_W-1:0]          pos_mag, pos_val;

  logic              div_start, div_busy, div_done;
  logic [STEP_W-1:0] div_steps;
  logic [NUM_W-1:0]  div_num, div_quot;
  logic [DEN_W-1:0]  div_den;

  logic       out_valid_r, out_free, load_out;
  steer_cmd_t steer_cmd;
  steer_rsp_t steer_rsp;

  assign raw_in[0] = in_chan.sensor_a;
  assign raw_in[1] = in_chan.sensor_b;
  assign raw_in[2] = in_chan.sensor_c;
  assign raw_in[3] = in_chan.sensor_d;
  assign raw_in[4] = in_chan.sensor_e;

  assign accept  = in_chan.valid && in_chan.ready;
  assign scan_in = accept && (op_t'(in_chan.op) == OP_SCAN);

  always_comb begin
    all_dark_in = 1'b1;
    all_mark_in = 1'b1;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (!(CMP_W'(raw_in[i]) > CMP_W'(cfg_r.dark_threshold))) all_dark_in = 1'b0;
      if (!(CMP_W'(raw_in[i]) < CMP_W'(cfg_r.dark_threshold))) all_mark_in = 1'b0;
    end
  end

  // per-sensor datapath
  assign span      = max_r[idx_r] - min_r[idx_r];
  assign diff      = raw_r[idx_r] - min_r[idx_r];
  assign norm_prod = div_quot[SAMPLE_BITS-1:0] * diff;
  assign wt_ext    = {{(ACC_W-3){SENSOR_WEIGHT[idx_r][2]}}, SENSOR_WEIGHT[idx_r]};
  assign norm_ext  = signed'({3'b000, norm_r});
  assign term      = wt_ext * norm_ext;
  assign wabs      = (wsum_r < 0) ? -wsum_r : wsum_r;
  assign wmag      = wabs[WMAG_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (scan_in) state_nxt = S_SPAN;
      S_SPAN:  state_nxt = (span == '0) ? S_ACC : S_GWAIT;
      S_GWAIT: if (div_done) state_nxt = S_ACC;
      S_ACC:   state_nxt = (idx_r == IDX_W'(SENSOR_COUNT - 1)) ? S_TOT : S_SPAN;
      S_TOT:   state_nxt = (total_r == '0) ? S_DRIVE : S_PWAIT;
      S_PWAIT: if (div_done) state_nxt = S_DRIVE;
      S_DRIVE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    div_start = 1'b0;
    div_steps = STEP_W'(SAMPLE_BITS);
    div_num   = {SMAX, {(NUM_W-SAMPLE_BITS){1'b0}}};
    div_den   = DEN_W'(span);
    load_out  = 1'b0;
    case (state_r)
      S_SPAN: div_start = (span != '0);
      S_TOT: begin
        div_start = (total_r != '0);
        div_steps = STEP_W'(NUM_W);
        div_num   = NUM_W'(cfg_r.position_scale) * NUM_W'(wmag);
        div_den   = total_r;
      end
      S_DRIVE: load_out = out_free;
      default: ;
    endcase
  end

  assign in_chan.ready = (state_r == S_IDLE);
  assign out_free      = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // setup registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dark_threshold <= DARK_THRESHOLD_RST;
      cfg_r.near_band      <= NEAR_BAND_RST;
      cfg_r.far_band       <= FAR_BAND_RST;
      cfg_r.cruise_drive   <= CRUISE_DRIVE_RST;
      cfg_r.position_scale <= POSITION_SCALE_RST;
      cfg_r.lap_lockout    <= LAP_LOCKOUT_RST;
      cfg_r.lap_limit      <= LAP_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DARK_THRESHOLD: cfg_r.dark_threshold <= cfg_data[THR_W-1:0];
        CFG_NEAR_BAND:      cfg_r.near_band      <= cfg_data[BAND_W-1:0];
        CFG_FAR_BAND:       cfg_r.far_band       <= cfg_data[BAND_W-1:0];
        CFG_CRUISE_DRIVE:   cfg_r.cruise_drive   <= cfg_data[DRIVE_W-1:0];
        CFG_POSITION_SCALE: cfg_r.position_scale <= cfg_data[SCALE_W-1:0];
        CFG_LAP_LOCKOUT:    cfg_r.lap_lockout    <= cfg_data[LOCK_W-1:0];
        CFG_LAP_LIMIT:      cfg_r.lap_limit      <= cfg_data[LAP_W-1:0];
        default: ;
      endcase
    end
  end

  // calibration extremes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        min_r[i] <= SMAX;
        max_r[i] <= '0;
      end
    end else if (accept && (op_t'(in_chan.op) == OP_RESTART)) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        min_r[i] <= SMAX;
        max_r[i] <= '0;
      end
    end else if (scan_in) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        if (raw_in[i] > max_r[i]) max_r[i] <= raw_in[i];
        if (raw_in[i] < min_r[i]) min_r[i] <= raw_in[i];
      end
    end
  end

  // scan working registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (scan_in) begin
        for (int i = 0; i < SENSOR_COUNT; i++) raw_r[i] <= raw_in[i];
        all_dark_r <= all_dark_in;
        all_mark_r <= all_mark_in;
        degen_r    <= 1'b0;
        wsum_r     <= '0;
        total_r    <= '0;
        idx_r      <= '0;
      end
      S_SPAN: if (span == '0) begin
        norm_r  <= '0;
        degen_r <= 1'b1;
      end
      S_GWAIT: if (div_done) norm_r <= norm_prod[SAMPLE_BITS-1:0];
      S_ACC: begin
        wsum_r  <= wsum_r + term;
        total_r <= total_r + ACC_W'(norm_r);
        idx_r   <= idx_r + 1'b1;
      end
      S_TOT: begin
        neg_r <= (wsum_r < 0);
        if (total_r == '0) begin
          mag_r   <= '0;
          degen_r <= 1'b1;
        end
      end
      S_PWAIT: if (div_done) mag_r <= div_quot[MAG_W-1:0];
      default: ;
    endcase
  end

  lss_divider #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .steps (div_steps),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    steer_cmd.tick     = accept && (op_t'(in_chan.op) == OP_TICK);
    steer_cmd.restart  = accept && (op_t'(in_chan.op) == OP_RESTART);
    steer_cmd.decide   = load_out;
    steer_cmd.all_dark = all_dark_r;
    steer_cmd.all_mark = all_mark_r;
    steer_cmd.neg      = neg_r;
    steer_cmd.mag      = mag_r;
  end

  lss_steer u_steer (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .cmd   (steer_cmd),
    .rsp   (steer_rsp)
  );

  assign pos_mag = {1'b0, mag_r};
  assign pos_val = neg_r ? (~pos_mag + 1'b1) : pos_mag;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_chan.right_drive <= steer_rsp.right_drive;
      out_chan.left_drive  <= steer_rsp.left_drive;
      out_chan.position    <= pos_val;
      out_chan.lap_count   <= steer_rsp.lap_count;
      out_chan.finished    <= steer_rsp.finished;
      out_chan.degenerate  <= degen_r;
    end
  end

  assign out_chan.valid = out_valid_r;

  a_finished_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.finished |->
      out_chan.right_drive == '0 && out_chan.left_drive == '0)
    else $error("drives nonzero after finish");

  a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !div_busy)
    else $error("ready while divider busy");

endmodule

>>> src/lss_divider.sv
// ----------------------------------------------------------------------------
// lss_divider
// Shared restoring divider, one quotient bit per cycle, variable step count.
// ----------------------------------------------------------------------------
module lss_divider import lss_pkg::*; #(
  parameter  int NUM_W  = DIV_NUM_W_DEF,
  parameter  int DEN_W  = DIV_DEN_W_DEF,
  localparam int STEP_W = $clog2(NUM_W + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [STEP_W-1:0] steps,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic              busy,
  output logic              done,
  output logic [NUM_W-1:0]  quot
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]  quot_r, quot_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W:0]    shifted;
  logic [DEN_W:0]    trial;
  logic              ge;

  assign shifted = {rem_r, quot_r[NUM_W-1]};
  assign ge      = (shifted >= {1'b0, den_r});
  assign trial   = shifted - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = steps;
      rem_nxt  = '0;
      quot_nxt = num;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt  = ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      quot_nxt = {quot_r[NUM_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    den_r  <= den_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quot_r;

  a_no_start_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

endmodule

>>> src/lss_steer.sv
// ----------------------------------------------------------------------------
// lss_steer
// Drive selection from position bands, dark search, lap lockout and counter.
// ----------------------------------------------------------------------------
module lss_steer import lss_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  steer_cmd_t cmd,
  output steer_rsp_t rsp
);

  logic [DRIVE_W-1:0] last_right_r, last_right_nxt;
  logic [DRIVE_W-1:0] last_left_r, last_left_nxt;
  logic [LAP_W-1:0]   laps_r, laps_nxt;
  logic [LOCK_W-1:0]  lockout_r, lockout_nxt;
  logic               run_over_r, run_over_nxt;
  logic [DRIVE_W-1:0] cruise;
  logic [DRIVE_W-1:0] right_pick;
  logic [DRIVE_W-1:0] left_pick;
  logic [LAP_W-1:0]   laps_inc;
  logic               mark;

  assign cruise = (cfg.cruise_drive > FULL_DUTY) ? FULL_DUTY : cfg.cruise_drive;

  always_comb begin
    if (cmd.mag > cfg.far_band) begin
      right_pick = cmd.neg ? STRONG_DRIVE : cruise;
      left_pick  = cmd.neg ? cruise : STRONG_DRIVE;
    end else if (cmd.mag > cfg.near_band) begin
      right_pick = cmd.neg ? GENTLE_DRIVE : cruise;
      left_pick  = cmd.neg ? cruise : GENTLE_DRIVE;
    end else if (cmd.all_dark) begin
      if (last_right_r < last_left_r) begin
        right_pick = SEARCH_DRIVE;
        left_pick  = cruise;
      end else begin
        right_pick = cruise;
        left_pick  = SEARCH_DRIVE;
      end
    end else begin
      right_pick = cruise;
      left_pick  = cruise;
    end
  end

  assign mark     = cmd.decide && !run_over_r && (lockout_r == '0) && cmd.all_mark;
  assign laps_inc = (laps_r < LAP_CAP) ? laps_r + 1'b1 : laps_r;

  always_comb begin
    last_right_nxt = last_right_r;
    last_left_nxt  = last_left_r;
    laps_nxt       = laps_r;
    lockout_nxt    = lockout_r;
    run_over_nxt   = run_over_r;
    if (cmd.restart) begin
      last_right_nxt = '0;
      last_left_nxt  = '0;
      laps_nxt       = '0;
      lockout_nxt    = '0;
      run_over_nxt   = 1'b0;
    end else if (cmd.tick) begin
      if (lockout_r != '0) begin
        lockout_nxt = lockout_r - 1'b1;
      end
    end else if (cmd.decide && !run_over_r) begin
      last_right_nxt = right_pick;
      last_left_nxt  = left_pick;
      if (mark) begin
        lockout_nxt  = cfg.lap_lockout;
        laps_nxt     = laps_inc;
        run_over_nxt = (laps_inc >= cfg.lap_limit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_right_r <= '0;
      last_left_r  <= '0;
      laps_r       <= '0;
      lockout_r    <= '0;
      run_over_r   <= 1'b0;
    end else begin
      last_right_r <= last_right_nxt;
      last_left_r  <= last_left_nxt;
      laps_r       <= laps_nxt;
      lockout_r    <= lockout_nxt;
      run_over_r   <= run_over_nxt;
    end
  end

  always_comb begin
    rsp.right_drive = run_over_nxt ? '0 : right_pick;
    rsp.left_drive  = run_over_nxt ? '0 : left_pick;
    rsp.lap_count   = laps_nxt;
    rsp.finished    = run_over_nxt;
  end

  a_laps_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.restart |=> laps_r >= $past(laps_r))
    else $error("lap count dropped without restart");

  a_finish_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    run_over_r && !cmd.restart |=> run_over_r)
    else $error("finish cleared without restart");

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for line_sensor_steering_unit. A directed table (reset
// values, extremes, drive choices, tick, restart, unused op) is followed by
// random phases under several register settings and idle patterns. Every
// accepted item runs through a behavioral predictor; each result item is
// compared with the oldest expected result (the table's, for typed rows).
// ----------------------------------------------------------------------------
module tb_top import lss_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SBITS       = 10;
  localparam int unsigned SMAX        = (1 << SBITS) - 1;
  localparam int          NUM_PHASES  = 8;
  localparam int          PHASE_ITEMS = 85;
  localparam int          SETTLE_CYC  = 100;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int MODE_NONE = 0;
  localparam int MODE_SEND = 1;
  localparam int MODE_RECV = 2;
  localparam int MODE_BOTH = 3;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SBITS-1:0] sensor_a;
    logic [SBITS-1:0] sensor_b;
    logic [SBITS-1:0] sensor_c;
    logic [SBITS-1:0] sensor_d;
    logic [SBITS-1:0] sensor_e;
  } scan_item_t;

  typedef struct packed {
    logic [DRIVE_W-1:0]      right_drive;
    logic [DRIVE_W-1:0]      left_drive;
    logic signed [POS_W-1:0] position;
    logic [LAP_W-1:0]        lap_count;
    logic                    finished;
    logic                    degenerate;
  } steer_res_t;

  typedef struct packed {
    scan_item_t item;
    logic       typed;
    steer_res_t res;
  } dir_row_t;

  // dark, near, far, cruise, scale, lockout, lap limit
  int unsigned phase_cfg [NUM_PHASES][7] = '{
    '{500,  10,  20,  60,  75,    3,  4},
    '{  0,   0,   0,   0,   1,    0,  1},
    '{1023, 255, 255, 100, 127, 4095, 31},
    '{600,  30,   5, 127,  75,    2,  3},
    '{400,   8,  40,  45,  50,    0,  0},
    '{512,  20,  60,  80, 100,    1,  6},
    '{300,   5,  15,  70,  20,    5,  2},
    '{700,  12,  25,  55,  75,    0, 31}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lss_in_if #(.SAMPLE_BITS(SBITS)) in_if ();
  lss_out_if                       out_if ();

  line_sensor_steering_unit #(.SAMPLE_BITS(SBITS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register shadow
  int unsigned dark_thr, near_bd, far_bd, cruise_set, pos_scale, lock_set, lap_lim;
  // block state shadow
  int unsigned cal_max [SENSOR_COUNT];
  int unsigned cal_min [SENSOR_COUNT];
  int unsigned prev_right, prev_left, laps, lock_left;
  bit          run_done;

  steer_res_t pending_steer [$];
  dir_row_t   dir_rows [$];
  int         mismatch_cnt = 0;
  int         idle_mode = MODE_NONE;

  function automatic void clear_calib();
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      cal_max[i] = 0;
      cal_min[i] = SMAX;
    end
    prev_right = 0;
    prev_left  = 0;
    laps       = 0;
    lock_left  = 0;
    run_done   = 1'b0;
  endfunction

  task automatic steer_predict(input scan_item_t it, output bit has_res,
                               output steer_res_t res);
    int unsigned rd [SENSOR_COUNT];
    int unsigned span, gain, norm, total, mag, pmag, cruise, r, l;
    int          wsum, pos;
    bit          degen, dark, mark;
    has_res = 1'b0;
    res     = '0;
    rd[0] = 32'(it.sensor_a);
    rd[1] = 32'(it.sensor_b);
    rd[2] = 32'(it.sensor_c);
    rd[3] = 32'(it.sensor_d);
    rd[4] = 32'(it.sensor_e);
    if (it.op == OP_TICK) begin
      if (lock_left != 0) lock_left--;
    end else if (it.op == OP_RESTART) begin
      clear_calib();
    end else if (it.op == OP_SCAN) begin
      wsum  = 0;
      total = 0;
      degen = 1'b0;
      dark  = 1'b1;
      mark  = 1'b1;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        if (cal_max[i] < rd[i]) cal_max[i] = rd[i];
        if (cal_min[i] > rd[i]) cal_min[i] = rd[i];
        if (cal_max[i] > cal_min[i]) begin
          span = cal_max[i] - cal_min[i];
          gain = SMAX / span;
          norm = gain * (rd[i] - cal_min[i]);
        end else begin
          norm  = 0;
          degen = 1'b1;
        end
        wsum  += (i - 2) * int'(norm);
        total += norm;
        if (!(rd[i] > dark_thr)) dark = 1'b0;
        if (!(rd[i] < dark_thr)) mark = 1'b0;
      end
      if (total == 0) begin
        degen = 1'b1;
        pos   = 0;
      end else begin
        if (wsum < 0) mag = -wsum;
        else mag = wsum;
        pmag = (pos_scale * mag) / total;
        pos  = (wsum < 0) ? -int'(pmag) : int'(pmag);
      end
      cruise = (cruise_set > FULL_DUTY) ? 32'(FULL_DUTY) : cruise_set;
      if (pos < 0 && pos < -int'(far_bd)) begin
        r = 32'(STRONG_DRIVE);
        l = cruise;
      end else if (pos < 0 && pos < -int'(near_bd)) begin
        r = 32'(GENTLE_DRIVE);
        l = cruise;
      end else if (pos >= 0 && pos > int'(far_bd)) begin
        r = cruise;
        l = 32'(STRONG_DRIVE);
      end else if (pos >= 0 && pos > int'(near_bd)) begin
        r = cruise;
        l = 32'(GENTLE_DRIVE);
      end else if (dark) begin
        if (prev_right < prev_left) begin
          r = 32'(SEARCH_DRIVE);
          l = cruise;
        end else begin
          r = cruise;
          l = 32'(SEARCH_DRIVE);
        end
      end else begin
        r = cruise;
        l = cruise;
      end
      if (!run_done) begin
        prev_right = r;
        prev_left  = l;
        if (lock_left == 0 && mark) begin
          lock_left = lock_set;
          if (laps < LAP_CAP) laps++;
          if (laps >= lap_lim) run_done = 1'b1;
        end
      end
      if (run_done) begin
        r = 0;
        l = 0;
      end
      res.right_drive = r[DRIVE_W-1:0];
      res.left_drive  = l[DRIVE_W-1:0];
      res.position    = pos[POS_W-1:0];
      res.lap_count   = laps[LAP_W-1:0];
      res.finished    = run_done;
      res.degenerate  = degen;
      has_res = 1'b1;
    end
  endtask

  function automatic bit sender_gap();
    case (idle_mode)
      MODE_SEND: return $urandom_range(0, 99) < 52;
      MODE_BOTH: return $urandom_range(0, 99) < 9;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit recv_stall();
    case (idle_mode)
      MODE_RECV: return $urandom_range(0, 99) < 52;
      MODE_BOTH: return $urandom_range(0, 99) < 9;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic void add_row(logic [OP_W-1:0] op, int a, int b, int c, int d,
                                  int e, bit typed, int r, int l, int pos,
                                  int lap, int fin, int deg);
    dir_row_t row;
    row.item.op          = op;
    row.item.sensor_a    = a[SBITS-1:0];
    row.item.sensor_b    = b[SBITS-1:0];
    row.item.sensor_c    = c[SBITS-1:0];
    row.item.sensor_d    = d[SBITS-1:0];
    row.item.sensor_e    = e[SBITS-1:0];
    row.typed            = typed;
    row.res.right_drive  = r[DRIVE_W-1:0];
    row.res.left_drive   = l[DRIVE_W-1:0];
    row.res.position     = pos[POS_W-1:0];
    row.res.lap_count    = lap[LAP_W-1:0];
    row.res.finished     = fin[0];
    row.res.degenerate   = deg[0];
    dir_rows.push_back(row);
  endfunction

  function automatic int unsigned gen_reading(int kind, int i, int peak, int base);
    int gap;
    case (kind)
      0, 1: return $urandom_range(0, SMAX);
      6:    return (dark_thr < SMAX) ? $urandom_range(dark_thr + 1, SMAX) : SMAX;
      7:    return (dark_thr > 0) ? $urandom_range(0, dark_thr - 1) : 0;
      8:    return $urandom_range(0, 1) ? SMAX : 0;
      9:    return (dark_thr > 0 && dark_thr < SMAX) ?
                   $urandom_range(dark_thr - 1, dark_thr + 1) : dark_thr;
      default: begin
        gap = (i > peak) ? i - peak : peak - i;
        if (gap == 0) return $urandom_range(700, SMAX);
        if (gap == 1 && $urandom_range(0, 1)) return $urandom_range(300, 800);
        return base + $urandom_range(0, 60);
      end
    endcase
  endfunction

  function automatic scan_item_t gen_item();
    scan_item_t it;
    int         sel, kind, peak, base;
    sel  = $urandom_range(0, 99);
    kind = $urandom_range(0, 9);
    peak = $urandom_range(0, SENSOR_COUNT - 1);
    base = $urandom_range(0, 350);
    if (sel < 72) it.op = OP_SCAN;
    else if (sel < 88) it.op = OP_TICK;
    else if (sel < 93) it.op = OP_RESTART;
    else it.op = OP_UNUSED;
    it.sensor_a = SBITS'(gen_reading(kind, 0, peak, base));
    it.sensor_b = SBITS'(gen_reading(kind, 1, peak, base));
    it.sensor_c = SBITS'(gen_reading(kind, 2, peak, base));
    it.sensor_d = SBITS'(gen_reading(kind, 3, peak, base));
    it.sensor_e = SBITS'(gen_reading(kind, 4, peak, base));
    return it;
  endfunction

  // called at a falling edge, returns at a falling edge with valid low
  task automatic push_item(scan_item_t it, bit typed, steer_res_t typed_res);
    bit         has_res;
    steer_res_t res;
    while (sender_gap()) @(negedge clk);
    in_if.valid    = 1'b1;
    in_if.op       = it.op;
    in_if.sensor_a = it.sensor_a;
    in_if.sensor_b = it.sensor_b;
    in_if.sensor_c = it.sensor_c;
    in_if.sensor_d = it.sensor_d;
    in_if.sensor_e = it.sensor_e;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    steer_predict(it, has_res, res);
    if (has_res) pending_steer.push_back(typed ? typed_res : res);
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  task automatic drain();
    while (pending_steer.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val[CFG_DATA_W-1:0];
    case (idx)
      CFG_DARK_THRESHOLD: dark_thr   = val & 'h3FF;
      CFG_NEAR_BAND:      near_bd    = val & 'hFF;
      CFG_FAR_BAND:       far_bd     = val & 'hFF;
      CFG_CRUISE_DRIVE:   cruise_set = val & 'h7F;
      CFG_POSITION_SCALE: pos_scale  = val & 'h7F;
      CFG_LAP_LOCKOUT:    lock_set   = val & 'hFFF;
      CFG_LAP_LIMIT:      lap_lim    = val & 'h1F;
      default: ;
    endcase
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_if.ready = !recv_stall();
  end

  always @(posedge clk) begin
    steer_res_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.right_drive = out_if.right_drive;
      got.left_drive  = out_if.left_drive;
      got.position    = out_if.position;
      got.lap_count   = out_if.lap_count;
      got.finished    = out_if.finished;
      got.degenerate  = out_if.degenerate;
      if (pending_steer.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("ERROR %0t: unexpected result r=%0d l=%0d pos=%0d lap=%0d fin=%0d deg=%0d",
                   $realtime, got.right_drive, got.left_drive, got.position,
                   got.lap_count, got.finished, got.degenerate);
      end else begin
        want = pending_steer.pop_front();
        if (got.right_drive !== want.right_drive || got.left_drive !== want.left_drive ||
            got.position !== want.position || got.lap_count !== want.lap_count ||
            got.finished !== want.finished || got.degenerate !== want.degenerate) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $write("ERROR %0t: exp r=%0d l=%0d pos=%0d lap=%0d fin=%0d deg=%0d,",
                   $realtime, want.right_drive, want.left_drive, want.position,
                   want.lap_count, want.finished, want.degenerate);
            $display(" got r=%0d l=%0d pos=%0d lap=%0d fin=%0d deg=%0d",
                     got.right_drive, got.left_drive, got.position,
                     got.lap_count, got.finished, got.degenerate);
          end
        end
      end
    end
  end

  initial begin
    #8ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    scan_item_t it;
    int         cnt;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_if.valid    = 1'b0;
    in_if.op       = OP_SCAN;
    in_if.sensor_a = '0;
    in_if.sensor_b = '0;
    in_if.sensor_c = '0;
    in_if.sensor_d = '0;
    in_if.sensor_e = '0;
    out_if.ready   = 1'b0;

    dark_thr   = 32'(DARK_THRESHOLD_RST);
    near_bd    = 32'(NEAR_BAND_RST);
    far_bd     = 32'(FAR_BAND_RST);
    cruise_set = 32'(CRUISE_DRIVE_RST);
    pos_scale  = 32'(POSITION_SCALE_RST);
    lock_set   = 32'(LAP_LOCKOUT_RST);
    lap_lim    = 32'(LAP_LIMIT_RST);
    clear_calib();

    add_row(OP_SCAN,       0,    0,    0,    0,    0, 1, 60, 60,    0, 1, 0, 1);
    add_row(OP_SCAN,       0,    0,    0,    0,    0, 1, 60, 60,    0, 1, 0, 1);
    add_row(OP_SCAN,    1023, 1023, 1023, 1023, 1023, 1, 60,  2,    0, 1, 0, 0);
    add_row(OP_SCAN,       0,    0,    0,    0, 1023, 1, 60,  5,  150, 1, 0, 0);
    add_row(OP_SCAN,    1023,    0,    0,    0,    0, 1,  5, 60, -150, 1, 0, 0);
    add_row(OP_SCAN,    1023, 1023, 1023, 1023, 1023, 1,  2, 60,    0, 1, 0, 0);
    add_row(OP_SCAN,       0,    0, 1023,    0,    0, 1, 60, 60,    0, 1, 0, 0);
    add_row(OP_SCAN,       0, 1023,    0,    0,    0, 1,  5, 60,  -75, 1, 0, 0);
    add_row(OP_SCAN,       0,    0,    0, 1023,    0, 1, 60,  5,   75, 1, 0, 0);
    add_row(OP_TICK,       0,    0,    0,    0,    0, 0,  0,  0,    0, 0, 0, 0);
    add_row(OP_UNUSED,  1023, 1023, 1023, 1023, 1023, 0,  0,  0,    0, 0, 0, 0);
    add_row(OP_SCAN,     300,  650,  900,  120, 1023, 0,  0,  0,    0, 0, 0, 0);
    add_row(OP_SCAN,    1023, 1023,    0,    0,    0, 0,  0,  0,    0, 0, 0, 0);
    add_row(OP_SCAN,       0,    0,    0, 1023, 1023, 0,  0,  0,    0, 0, 0, 0);
    add_row(OP_RESTART,    0,    0,    0,    0,    0, 0,  0,  0,    0, 0, 0, 0);
    add_row(OP_SCAN,       0,    0,    0,    0,    0, 1, 60, 60,    0, 1, 0, 1);
    add_row(OP_TICK,    1023, 1023, 1023, 1023, 1023, 0,  0,  0,    0, 0, 0, 0);
    add_row(OP_SCAN,     499,  499,  499,  499,  499, 0,  0,  0,    0, 0, 0, 0);
    add_row(OP_SCAN,     500,  500,  500,  500,  500, 0,  0,  0,    0, 0, 0, 0);
    add_row(OP_SCAN,     501,  501,  501,  501,  501, 0,  0,  0,    0, 0, 0, 0);
    add_row(OP_SCAN,    1023,    0, 1023,    0, 1023, 0,  0,  0,    0, 0, 0, 0);

    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) push_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      idle_mode = MODE_NONE;
      drain();
      repeat (SETTLE_CYC) @(negedge clk);
      for (int k = 0; k < 7; k++) write_reg(cfg_idx_t'(k), phase_cfg[ph][k]);
      cfg_we    = 1'b0;
      idle_mode = ph % 4;
      cnt = 0;
      while (cnt < PHASE_ITEMS) begin
        it = gen_item();
        if (it.op != OP_UNUSED) cnt++;
        push_item(it, 1'b0, '0);
        // hold the sender until the block is empty
        if (cnt == PHASE_ITEMS / 2 && it.op != OP_UNUSED) drain();
      end
    end

    drain();
    repeat (SETTLE_CYC) @(negedge clk);
    if (mismatch_cnt == 0 && pending_steer.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
